/* design/iee_pkg.sv */
// package for the infix expression evaluator
// types, character codes, operator codes and helpers shared by all modules
`timescale 1ns / 1ps
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAL_W           = 32;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;

    localparam logic [2:0] OP_LPAR = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef enum logic [2:0] {
        CL_DIGIT, CL_LPAR, CL_RPAR, CL_OPER, CL_EQ, CL_UNK
    } t_cls;

    typedef enum logic [1:0] {
        VS_TOP, VS_NEXT, VS_BASE
    } t_vsel;

    typedef struct packed {
        logic       latch_char;
        logic       push_val;
        logic       push_lpar;
        logic       push_cur;
        logic       pop_op;
        logic       set_want;
        logic       clr_want;
        logic [1:0] err;
        t_vsel      vsel;
        logic       lat_rhs;
        logic       exec;
        logic       div_start;
        logic       wb;
        logic       fin_load;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic want;
        logic err_nz;
        logic op_empty;
        logic val_lt2;
        logic val_ne1;
        logic top_lpar;
        logic pop_ok;
        logic op_div;
        logic rhs_zero;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

/* design/iee_div.sv */
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on iee_pkg
`timescale 1ns / 1ps
module iee_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [iee_pkg::VAL_W-1:0] i_a,
    input  logic [iee_pkg::VAL_W-1:0] i_b,
    output logic                     o_done,
    output logic [iee_pkg::VAL_W-1:0] o_q
);
    localparam int W  = iee_pkg::VAL_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_mb, n_mb;
    logic          r_neg, n_neg;
    logic [W-1:0]  r_q, n_q;
    logic [W:0]    w_sh, w_diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_mb   = r_mb;
        n_neg  = r_neg;
        n_q    = r_q;
        w_sh   = {r_rem[W-1:0], r_quo[W-1]};
        w_diff = w_sh - {1'b0, r_mb};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_a[W-1] ? (~i_a + 1'b1) : i_a;
            n_mb   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
            n_neg  = i_a[W-1] ^ i_b[W-1];
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_rem = w_diff;
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_q    = r_neg ? (~n_quo + 1'b1) : n_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_mb  <= n_mb;
        r_neg <= n_neg;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

/* design/iee_dp.sv */
// datapath: character register, operator and value stacks, alu, output register
// depends on iee_pkg and iee_div
`timescale 1ns / 1ps
module iee_dp #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_char,
    input  iee_pkg::t_cmd             i_cmd,
    output iee_pkg::t_sts             o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [iee_pkg::VAL_W-1:0] o_value,
    output logic [1:0]                o_status
);
    localparam int W  = iee_pkg::VAL_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]   op_mem  [STACK_DEPTH];
    logic [W-1:0] val_mem [STACK_DEPTH];

    logic [7:0]    r_char;
    logic [CW-1:0] r_op_cnt, r_val_cnt;
    logic [1:0]    r_err;
    logic          r_want;
    logic [2:0]    r_op_q;
    logic [W-1:0]  r_val_q, r_rhs, r_res;
    logic          r_out_valid;
    logic [W-1:0]  r_value;
    logic [1:0]    r_status;

    iee_pkg::t_cls w_cls;
    logic [2:0]    w_cur;
    logic          w_op_full, w_val_full, w_ovf;
    logic          w_op_we, w_val_we;
    logic [AW-1:0] w_op_wa, w_val_wa, w_op_ra, w_val_ra;
    logic [2:0]    w_op_wd;
    logic [W-1:0]  w_val_wd;
    logic [1:0]    w_code;
    logic          w_div_done;
    logic [W-1:0]  w_div_q;

    always_comb begin
        w_cur = iee_pkg::OP_ADD;
        w_cls = iee_pkg::CL_UNK;
        if (r_char >= iee_pkg::CH_ZERO && r_char <= iee_pkg::CH_NINE) begin
            w_cls = iee_pkg::CL_DIGIT;
        end
        case (r_char)
            iee_pkg::CH_EQ:   w_cls = iee_pkg::CL_EQ;
            iee_pkg::CH_LPAR: w_cls = iee_pkg::CL_LPAR;
            iee_pkg::CH_RPAR: w_cls = iee_pkg::CL_RPAR;
            iee_pkg::CH_ADD: begin
                w_cls = iee_pkg::CL_OPER;
                w_cur = iee_pkg::OP_ADD;
            end
            iee_pkg::CH_SUB: begin
                w_cls = iee_pkg::CL_OPER;
                w_cur = iee_pkg::OP_SUB;
            end
            iee_pkg::CH_MUL: begin
                w_cls = iee_pkg::CL_OPER;
                w_cur = iee_pkg::OP_MUL;
            end
            iee_pkg::CH_DIV: begin
                w_cls = iee_pkg::CL_OPER;
                w_cur = iee_pkg::OP_DIV;
            end
            default: ;
        endcase
    end

    assign w_op_full  = (r_op_cnt == CW'(STACK_DEPTH));
    assign w_val_full = (r_val_cnt == CW'(STACK_DEPTH));
    assign w_ovf      = ((i_cmd.push_lpar || i_cmd.push_cur) && w_op_full)
                      || (i_cmd.push_val && w_val_full);
    assign w_op_ra    = r_op_cnt[AW-1:0] - 1'b1;
    assign w_op_wa    = r_op_cnt[AW-1:0];
    assign w_op_we    = (i_cmd.push_lpar || i_cmd.push_cur) && !w_op_full;
    assign w_op_wd    = i_cmd.push_cur ? w_cur : iee_pkg::OP_LPAR;

    always_comb begin
        case (i_cmd.vsel)
            iee_pkg::VS_TOP:  w_val_ra = r_val_cnt[AW-1:0] - 1'b1;
            iee_pkg::VS_NEXT: w_val_ra = r_val_cnt[AW-1:0] - AW'(2);
            default:          w_val_ra = '0;
        endcase
        if (i_cmd.wb) begin
            w_val_we = 1'b1;
            w_val_wa = r_val_cnt[AW-1:0] - AW'(2);
            w_val_wd = (r_op_q == iee_pkg::OP_DIV) ? w_div_q : r_res;
        end else begin
            w_val_we = i_cmd.push_val && !w_val_full;
            w_val_wa = r_val_cnt[AW-1:0];
            w_val_wd = {{(W-4){1'b0}}, r_char[3:0]};
        end
        w_code = (i_cmd.err != iee_pkg::ST_OK) ? i_cmd.err
               : (w_ovf ? iee_pkg::ST_OVF : iee_pkg::ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (w_op_we) begin
            op_mem[w_op_wa] <= w_op_wd;
        end
        r_op_q <= op_mem[w_op_ra];
        if (w_val_we) begin
            val_mem[w_val_wa] <= w_val_wd;
        end
        r_val_q <= val_mem[w_val_ra];
    end

    iee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (r_val_q),
        .i_b     (r_rhs),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_char) begin
            r_char <= i_char;
        end
        if (i_cmd.lat_rhs) begin
            r_rhs <= r_val_q;
        end
        if (i_cmd.exec) begin
            case (r_op_q)
                iee_pkg::OP_ADD: r_res <= r_val_q + r_rhs;
                iee_pkg::OP_SUB: r_res <= r_val_q - r_rhs;
                iee_pkg::OP_MUL: r_res <= r_val_q * r_rhs;
                default:         r_res <= '0;
            endcase
        end
        if (i_cmd.fin_load) begin
            r_value  <= (r_err == iee_pkg::ST_OK) ? r_val_q : '0;
            r_status <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_cnt    <= '0;
            r_val_cnt   <= '0;
            r_err       <= iee_pkg::ST_OK;
            r_want      <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_op_cnt    <= '0;
            r_val_cnt   <= '0;
            r_err       <= iee_pkg::ST_OK;
            r_want      <= 1'b1;
            r_out_valid <= 1'b1;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_op_we) begin
                r_op_cnt <= r_op_cnt + 1'b1;
            end else if (i_cmd.pop_op || i_cmd.wb) begin
                r_op_cnt <= r_op_cnt - 1'b1;
            end
            if (i_cmd.wb) begin
                r_val_cnt <= r_val_cnt - 1'b1;
            end else if (w_val_we) begin
                r_val_cnt <= r_val_cnt + 1'b1;
            end
            if (r_err == iee_pkg::ST_OK && w_code != iee_pkg::ST_OK) begin
                r_err <= w_code;
            end
            if (i_cmd.set_want) begin
                r_want <= 1'b1;
            end else if (i_cmd.clr_want) begin
                r_want <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cls      = w_cls;
        o_sts.want     = r_want;
        o_sts.err_nz   = (r_err != iee_pkg::ST_OK);
        o_sts.op_empty = (r_op_cnt == '0);
        o_sts.val_lt2  = (r_val_cnt < CW'(2));
        o_sts.val_ne1  = (r_val_cnt != CW'(1));
        o_sts.top_lpar = (r_op_q == iee_pkg::OP_LPAR);
        o_sts.pop_ok   = (r_op_cnt != '0)
                       && (iee_pkg::prec(r_op_q) >= iee_pkg::prec(w_cur));
        o_sts.op_div   = (r_op_q == iee_pkg::OP_DIV);
        o_sts.rhs_zero = (r_rhs == '0);
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

    a_op_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op_cnt <= CW'(STACK_DEPTH))
        else $error("operator count beyond depth");
    a_val_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val_cnt <= CW'(STACK_DEPTH))
        else $error("value count beyond depth");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_load |=> r_out_valid && r_op_cnt == '0 && r_val_cnt == '0
                           && r_err == iee_pkg::ST_OK)
        else $error("stacks not cleared after result");
    a_wb_has_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> r_val_cnt >= CW'(2) && r_op_cnt != '0)
        else $error("apply without operands");
endmodule

/* design/iee_ctrl.sv */
// controller state machine: decodes characters and sequences operator application
// depends on iee_pkg
`timescale 1ns / 1ps
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iee_pkg::t_sts i_sts,
    output iee_pkg::t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_DECODE  = 11'b00000000010,
        S_POP_RD  = 11'b00000000100,
        S_POP_CHK = 11'b00000001000,
        S_AP_V1   = 11'b00000010000,
        S_AP_V2   = 11'b00000100000,
        S_AP_EX   = 11'b00001000000,
        S_AP_DIV  = 11'b00010000000,
        S_AP_WB   = 11'b00100000000,
        S_FIN     = 11'b01000000000,
        S_FIN2    = 11'b10000000000
    } t_state;

    t_state        r_state, n_state;
    iee_pkg::t_cls r_mode, n_mode;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_cmd.vsel = iee_pkg::VS_BASE;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_char = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_mode  = i_sts.cls;
                n_state = S_IDLE;
                if (i_sts.cls == iee_pkg::CL_EQ) begin
                    if (i_sts.want) begin
                        o_cmd.err = iee_pkg::ST_BAD;
                    end
                    n_state = S_POP_RD;
                end else if (!i_sts.err_nz) begin
                    case (i_sts.cls)
                        iee_pkg::CL_DIGIT: begin
                            if (!i_sts.want) begin
                                o_cmd.err = iee_pkg::ST_BAD;
                            end else begin
                                o_cmd.push_val = 1'b1;
                                o_cmd.clr_want = 1'b1;
                            end
                        end
                        iee_pkg::CL_LPAR: begin
                            if (!i_sts.want) begin
                                o_cmd.err = iee_pkg::ST_BAD;
                            end else begin
                                o_cmd.push_lpar = 1'b1;
                            end
                        end
                        iee_pkg::CL_RPAR, iee_pkg::CL_OPER: begin
                            if (i_sts.want) begin
                                o_cmd.err = iee_pkg::ST_BAD;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        default: o_cmd.err = iee_pkg::ST_BAD;
                    endcase
                end
            end
            S_POP_RD: n_state = S_POP_CHK;
            S_POP_CHK: begin
                n_state = S_AP_V1;
                case (r_mode)
                    iee_pkg::CL_EQ: begin
                        if (i_sts.err_nz || i_sts.op_empty) begin
                            n_state = S_FIN;
                        end else if (i_sts.top_lpar) begin
                            o_cmd.err = iee_pkg::ST_BAD;
                            n_state = S_FIN;
                        end
                    end
                    iee_pkg::CL_RPAR: begin
                        if (i_sts.err_nz) begin
                            n_state = S_IDLE;
                        end else if (i_sts.op_empty) begin
                            o_cmd.err = iee_pkg::ST_BAD;
                            n_state = S_IDLE;
                        end else if (i_sts.top_lpar) begin
                            o_cmd.pop_op = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_sts.err_nz) begin
                            o_cmd.set_want = 1'b1;
                            n_state = S_IDLE;
                        end else if (!i_sts.pop_ok) begin
                            o_cmd.push_cur = 1'b1;
                            o_cmd.set_want = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
                if (n_state == S_AP_V1 && i_sts.val_lt2) begin
                    o_cmd.err = iee_pkg::ST_BAD;
                    n_state = S_POP_RD;
                end
            end
            S_AP_V1: begin
                o_cmd.vsel = iee_pkg::VS_TOP;
                n_state = S_AP_V2;
            end
            S_AP_V2: begin
                o_cmd.lat_rhs = 1'b1;
                o_cmd.vsel = iee_pkg::VS_NEXT;
                n_state = S_AP_EX;
            end
            S_AP_EX: begin
                if (i_sts.op_div) begin
                    if (i_sts.rhs_zero) begin
                        o_cmd.err = iee_pkg::ST_DIV0;
                        n_state = S_POP_RD;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_AP_DIV;
                    end
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_AP_WB;
                end
            end
            S_AP_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_AP_WB;
                end
            end
            S_AP_WB: begin
                o_cmd.wb = 1'b1;
                n_state = S_POP_RD;
            end
            S_FIN: begin
                if (!i_sts.err_nz && i_sts.val_ne1) begin
                    o_cmd.err = iee_pkg::ST_BAD;
                end
                n_state = S_FIN2;
            end
            S_FIN2: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= iee_pkg::CL_UNK;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_wb_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb |=> r_state == S_POP_RD)
        else $error("write-back not followed by stack check");
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin_load |=> !o_cmd.fin_load && r_state == S_IDLE)
        else $error("result loaded twice");
endmodule

/* design/infix_expression_evaluator_top.sv */
// top level of the infix expression evaluator
// ties iee_ctrl and iee_dp together; depends on iee_pkg
//
// usage: one ascii character per input word on the slave stream (tdata[7:0]).
// digits, + - * / and parentheses build the expression, '=' ends it.
// only '=' produces an output word on the master stream:
//   tdata[31:0] value (two's complement), tdata[33:32] status, upper bits zero.
// status 0 ok, 1 divide by zero, 2 stack overflow, 3 malformed or unknown.
// one character is taken at a time; tready is high only while the
// controller is idle. a digit or '(' is decoded and the controller returns
// to idle; an operator, ')' or '=' also checks the operator stack and
// applies each operator popped from it, with each division run in the divider
// (one quotient bit per cycle). '=' then does the final check and the result load.
// the result sits in an output register, so new characters are accepted
// while it waits; a following '=' holds until the register is taken.
// reset (synchronous, active low) empties both stacks and clears the error state.
`timescale 1ns / 1ps
module infix_expression_evaluator_top #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_code
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // value[31:0], status[33:32]
);
    iee_pkg::t_cmd w_cmd;
    iee_pkg::t_sts w_sts;
    logic [iee_pkg::VAL_W-1:0] w_value;
    logic [1:0]                w_status;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    iee_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_value     (w_value),
        .o_status    (w_status)
    );

    assign o_m_axis_tdata = {6'd0, w_status, w_value};
endmodule

/* test/testbench.sv */
// testbench for infix_expression_evaluator_top
// drives random and directed ascii expressions, predicts results with a
// shunting-yard model and checks each output word; depends on iee_pkg
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

    class expr_scoreboard;
        logic [2:0]  ops[$];
        logic [31:0] vals[$];
        logic [1:0]  err;
        bit          want;
        t_result     pending[$];
        int          fails;

        function void clear_stacks();
            ops.delete();
            vals.delete();
            err = iee_pkg::ST_OK;
            want = 1;
        endfunction

        function void flag(logic [1:0] e);
            if (err == iee_pkg::ST_OK) err = e;
        endfunction

        function logic [1:0] rank(logic [2:0] op);
            if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 2'd1;
            if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2'd2;
            return 2'd0;
        endfunction

        function void reduce_top();
            logic [2:0]  op;
            logic [31:0] l, r, q, ml, mr;
            if (ops.size() == 0 || vals.size() < 2) begin
                flag(iee_pkg::ST_BAD);
                return;
            end
            op = ops.pop_back();
            r = vals[vals.size() - 1];
            l = vals[vals.size() - 2];
            case (op)
                iee_pkg::OP_ADD: q = l + r;
                iee_pkg::OP_SUB: q = l - r;
                iee_pkg::OP_MUL: q = l * r;
                iee_pkg::OP_DIV: begin
                    if (r == 0) begin
                        flag(iee_pkg::ST_DIV0);
                        return;
                    end
                    ml = l[31] ? -l : l;
                    mr = r[31] ? -r : r;
                    q = ml / mr;
                    if (l[31] != r[31]) q = -q;
                end
                default: begin
                    flag(iee_pkg::ST_BAD);
                    return;
                end
            endcase
            void'(vals.pop_back());
            vals[vals.size() - 1] = q;
        endfunction

        function void note_char(logic [7:0] c);
            t_result res;
            logic [2:0] op;
            if (c == iee_pkg::CH_EQ) begin
                if (err == iee_pkg::ST_OK && want) flag(iee_pkg::ST_BAD);
                while (err == iee_pkg::ST_OK && ops.size() > 0) begin
                    if (ops[ops.size() - 1] == iee_pkg::OP_LPAR) flag(iee_pkg::ST_BAD);
                    else reduce_top();
                end
                if (err == iee_pkg::ST_OK && vals.size() != 1) flag(iee_pkg::ST_BAD);
                res.value = (err == iee_pkg::ST_OK) ? vals[0] : 32'd0;
                res.status = err;
                pending.push_back(res);
                clear_stacks();
                return;
            end
            if (err != iee_pkg::ST_OK) return;
            if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
                if (!want) begin
                    flag(iee_pkg::ST_BAD);
                    return;
                end
                if (vals.size() >= iee_pkg::STACK_DEPTH_DEF) flag(iee_pkg::ST_OVF);
                else vals.push_back(32'(c - iee_pkg::CH_ZERO));
                want = 0;
                return;
            end
            case (c)
                iee_pkg::CH_LPAR: begin
                    if (!want) flag(iee_pkg::ST_BAD);
                    else if (ops.size() >= iee_pkg::STACK_DEPTH_DEF) flag(iee_pkg::ST_OVF);
                    else ops.push_back(iee_pkg::OP_LPAR);
                    return;
                end
                iee_pkg::CH_RPAR: begin
                    if (want) begin
                        flag(iee_pkg::ST_BAD);
                        return;
                    end
                    while (err == iee_pkg::ST_OK && ops.size() > 0
                           && ops[ops.size() - 1] != iee_pkg::OP_LPAR)
                        reduce_top();
                    if (err != iee_pkg::ST_OK) return;
                    if (ops.size() == 0) flag(iee_pkg::ST_BAD);
                    else void'(ops.pop_back());
                    return;
                end
                iee_pkg::CH_ADD: op = iee_pkg::OP_ADD;
                iee_pkg::CH_SUB: op = iee_pkg::OP_SUB;
                iee_pkg::CH_MUL: op = iee_pkg::OP_MUL;
                iee_pkg::CH_DIV: op = iee_pkg::OP_DIV;
                default: begin
                    flag(iee_pkg::ST_BAD);
                    return;
                end
            endcase
            if (want) begin
                flag(iee_pkg::ST_BAD);
                return;
            end
            while (err == iee_pkg::ST_OK && ops.size() > 0
                   && rank(ops[ops.size() - 1]) >= rank(op))
                reduce_top();
            if (err == iee_pkg::ST_OK) begin
                if (ops.size() >= iee_pkg::STACK_DEPTH_DEF) flag(iee_pkg::ST_OVF);
                else ops.push_back(op);
            end
            want = 1;
        endfunction

        function void check_word(logic [39:0] w);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected word %h", w);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (w[31:0] !== e.value) begin
                $error("value expected %0d actual %0d", $signed(e.value), $signed(w[31:0]));
                fails++;
            end
            if (w[33:32] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, w[33:32]);
                fails++;
            end
            if (w[39:34] !== 6'd0) begin
                $error("pad expected 0 actual %h", w[39:34]);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_data = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [39:0] m_data;
    bit          hold_off = 0;
    bit          stop_drain = 0;
    expr_scoreboard sb = new();

    infix_expression_evaluator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),   // char_code
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data)    // value[31:0], status[33:32]
    );

    always #4 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_char(logic [7:0] c);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1;
        s_data <= c;
        do @(posedge i_clk); while (!s_ready);
        sb.note_char(c);
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // well-formed expression with random content
    function string gen_expr(int depth);
        string s, ops;
        int n;
        ops = "+-*/";
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) s = {s, string'(ops[$urandom_range(0, 3)])};
            if (depth > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", gen_expr(depth - 1), ")"};
            else
                s = {s, string'(8'(iee_pkg::CH_ZERO + $urandom_range(0, 9)))};
        end
        return s;
    endfunction

    // receiver
    initial begin
        int g;
        while (!stop_drain) begin
            @(posedge i_clk);
            if (m_valid && m_ready) sb.check_word(m_data);
            if (hold_off) m_ready <= 0;
            else begin
                g = gap_len();
                m_ready <= (g == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int sent;
        string s;
        sb.clear_stacks();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_str("9*9*9=");
        send_str("0=");
        send_str("1+2*3-4/2=");
        send_str("(1+2)*(3-9)=");
        send_str("7/0=");
        send_str("=");
        send_str("1+=");
        send_str("12=");
        send_str("(3=");
        send_str("3)=");
        send_str("x5=");
        send_str("9-8-7/2=");
        s = "";
        for (int i = 0; i < 70; i++) s = {s, "("};
        send_str({s, "="});
        s = "1";
        for (int i = 0; i < 66; i++) s = {s, "*1"};
        send_str({s, "="});
        wait_drained();

        // hold off the receiver while characters keep coming
        hold_off = 1;
        fork
            begin
                repeat (2000) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 6; k++) send_str({gen_expr(2), "="});
        join
        wait_drained();

        sent = 0;
        while (sent < 1100) begin
            int r;
            r = $urandom_range(0, 19);
            if (r < 15) s = {gen_expr(3), "="};
            else if (r < 18) begin
                s = gen_expr(2);
                s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
                s = {s, "="};
            end else if (r == 18) s = {"2147483647*9-0/7*2=", ""};
            else begin
                s = "";
                for (int i = 0; i < 5; i++) s = {s, string'(8'($urandom_range(0, 255)))};
                s = {s, "="};
            end
            send_str(s);
            sent += s.len();
            if ($urandom_range(0, 30) == 0) wait_drained();
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        stop_drain = 1;
        if (sb.fails == 0 && sb.pending.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
design/iee_pkg.sv
design/iee_div.sv
design/iee_dp.sv
design/iee_ctrl.sv
design/infix_expression_evaluator_top.sv
test/testbench.sv
